/* hdl/ckor_pkg.sv */
// Shared types and constants for the client key table with oldest-entry replacement.
// No dependencies.
package ckor_pkg;

  localparam int KEY_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int MODE_W       = 2;
  localparam int SLOT_W       = 6;
  localparam int USED_W       = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd2;

  typedef struct packed {
    logic               key_en;
    logic               stamp_en;
    logic               set_valid;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } cell_wr_t;

endpackage

/* hdl/client_key_table_oldest_replace_unit.sv */
// Client key table with oldest-entry replacement: a chain of cells with a registered FSM.
// An accepted start steps through S_CMP, S_ENC and S_ACT; done is registered on leaving
// S_ACT, one item at a time. Insert on a full table waits in S_ACT until the oldest-stamp
// chain has settled after the last table write; the chain moves one cell per cycle.
// Reset clears all valid bits and the used count at once; the block is ready after reset.
// The receiver cannot stall: done is high for one cycle per item. Depends on ckor_pkg.
module client_key_table_oldest_replace_unit import ckor_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [KEY_W-1:0]   key,
  input  logic [STAMP_W-1:0] now,
  output logic               done,
  output logic               found,
  output logic [SLOT_W-1:0]  slot,
  output logic [USED_W-1:0]  used
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_ENC, S_ACT} state_t;

  state_t             state;
  logic [MODE_W-1:0]  mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [STAMP_W-1:0] now_r;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] match_w;
  logic [TABLE_DEPTH-1:0] valid_w;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic               hit_any_w;
  logic [IDX_W-1:0]   hit_idx_w;
  logic               free_any_w;
  logic [IDX_W-1:0]   free_idx_w;
  logic [CNT_W-1:0]   used_count;
  logic [CNT_W-1:0]   settle;
  logic               settled;

  logic               wr_go;
  logic [IDX_W-1:0]   wr_idx;
  logic               act_done;
  cell_wr_t           wr;

  logic [STAMP_W-1:0] chain_stamp [0:TABLE_DEPTH];
  logic [IDX_W-1:0]   chain_idx   [0:TABLE_DEPTH];

  assign chain_stamp[0] = '0;
  assign chain_idx[0]   = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ckor_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(i),
      .FIRST   (i == 0)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .sel           (wr_go && (wr_idx == IDX_W'(i))),
      .wr            (wr),
      .cmp_key       (key_r),
      .match         (match_w[i]),
      .valid         (valid_w[i]),
      .carry_stamp_in(chain_stamp[i]),
      .carry_idx_in  (chain_idx[i]),
      .carry_stamp   (chain_stamp[i+1]),
      .carry_idx     (chain_idx[i+1])
    );
  end

  ckor_prio #(.WIDTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_hit_prio (
    .flags(hit_vec),
    .any  (hit_any_w),
    .idx  (hit_idx_w)
  );

  ckor_prio #(.WIDTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_free_prio (
    .flags(free_vec),
    .any  (free_any_w),
    .idx  (free_idx_w)
  );

  assign busy    = (state != S_IDLE);
  assign settled = (settle == CNT_W'(TABLE_DEPTH));

  always_comb begin
    wr_go        = 1'b0;
    wr_idx       = hit_idx;
    act_done     = 1'b0;
    wr.key_en    = 1'b0;
    wr.stamp_en  = 1'b1;
    wr.set_valid = 1'b0;
    wr.key       = key_r;
    wr.stamp     = now_r;
    if (state == S_ACT) begin
      case (mode_r)
        MODE_INSERT: begin
          wr.key_en = 1'b1;
          if (free_any) begin
            wr_go        = 1'b1;
            wr_idx       = free_idx;
            wr.set_valid = 1'b1;
            act_done     = 1'b1;
          end else if (settled) begin
            wr_go    = 1'b1;
            wr_idx   = chain_idx[TABLE_DEPTH];
            act_done = 1'b1;
          end
        end
        MODE_REFRESH: begin
          wr_go    = hit_any;
          act_done = 1'b1;
        end
        default: begin
          act_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      found      <= 1'b0;
      slot       <= '0;
      used       <= '0;
      used_count <= '0;
      settle     <= '0;
    end else begin
      done <= 1'b0;
      if (wr_go) begin
        settle <= '0;
      end else if (!settled) begin
        settle <= settle + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_ENC;
        end
        S_ENC: begin
          state <= S_ACT;
        end
        S_ACT: begin
          if (act_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (wr_go && wr.set_valid) begin
              used_count <= used_count + 1'b1;
            end
            if (mode_r == MODE_INSERT) begin
              found <= 1'b1;
              slot  <= SLOT_W'(wr_idx);
              used  <= USED_W'(used_count + CNT_W'(free_any));
            end else begin
              found <= hit_any;
              slot  <= hit_any ? SLOT_W'(hit_idx) : '0;
              used  <= USED_W'(used_count);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: request latch, compare vectors, encoder results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mode_r <= mode;
      key_r  <= key;
      now_r  <= now;
    end
    if (state == S_CMP) begin
      hit_vec  <= match_w;
      free_vec <= ~valid_w;
    end
    if (state == S_ENC) begin
      hit_any  <= hit_any_w;
      hit_idx  <= hit_idx_w;
      free_any <= free_any_w;
      free_idx <= free_idx_w;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(TABLE_DEPTH))
    else $error("used count exceeds table depth");

  a_insert_found: assert property (@(posedge clk) disable iff (rst)
    (done && mode_r == MODE_INSERT) |-> found)
    else $error("insert item reported without found");

  a_done_on_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_write_only_in_act: assert property (@(posedge clk) disable iff (rst)
    wr_go |-> (state == S_ACT && act_done))
    else $error("table write outside the action step");

endmodule

/* hdl/ckor_cell.sv */
// One table cell: key, stamp and valid bit, key compare, and one step of the oldest-stamp chain.
// Depends on ckor_pkg.
module ckor_cell import ckor_pkg::*; #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0,
  parameter bit FIRST    = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sel,
  input  cell_wr_t           wr,
  input  logic [KEY_W-1:0]   cmp_key,
  output logic               match,
  output logic               valid,
  input  logic [STAMP_W-1:0] carry_stamp_in,
  input  logic [IDX_W-1:0]   carry_idx_in,
  output logic [STAMP_W-1:0] carry_stamp,
  output logic [IDX_W-1:0]   carry_idx
);

  logic [KEY_W-1:0]   key;
  logic [STAMP_W-1:0] stamp;
  logic               take_own;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && wr.set_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.key_en) begin
      key <= wr.key;
    end
    if (sel && wr.stamp_en) begin
      stamp <= wr.stamp;
    end
  end

  assign match    = valid && (key == cmp_key);
  assign take_own = FIRST || (stamp < carry_stamp_in);

  // advance the running minimum one cell per cycle; ties keep the lower index
  always_ff @(posedge clk) begin
    if (take_own) begin
      carry_stamp <= stamp;
      carry_idx   <= IDX_W'(CELL_IDX);
    end else begin
      carry_stamp <= carry_stamp_in;
      carry_idx   <= carry_idx_in;
    end
  end

endmodule

/* hdl/ckor_prio.sv */
// Lowest-index priority encoder over a flag vector.
// Depends on ckor_pkg.
module ckor_prio import ckor_pkg::*; #(
  parameter int WIDTH = DEFAULT_DEPTH,
  parameter int IDX_W = 6
) (
  input  logic [WIDTH-1:0] flags,
  output logic             any,
  output logic [IDX_W-1:0] idx
);

  always_comb begin
    any = |flags;
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (flags[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

/* tb/client_key_table_oldest_replace_unit_test.sv */
// Testbench for client_key_table_oldest_replace_unit: bursty request driver, result checker
// against an in-bench table predictor, and a no-progress watchdog.
// Depends on ckor_pkg and the unit under test.
module client_key_table_oldest_replace_unit_test import ckor_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int RANDOM_REQUESTS = 850;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_MAX = 96;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  now;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] mode = '0;
  logic [KEY_W-1:0]  key = '0;
  logic [KEY_W-1:0]  now = '0;
  logic              done;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic [USED_W-1:0] used;

  request_t requests[$];
  answer_t  answers_due[$];
  logic [KEY_W-1:0] key_pool[$];

  logic [KEY_W-1:0] cell_key[DEPTH];
  logic [KEY_W-1:0] cell_stamp[DEPTH];
  bit               cell_valid[DEPTH];
  int               occupancy = 0;

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  client_key_table_oldest_replace_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .key(key), .now(now),
    .done(done), .found(found), .slot(slot), .used(used)
  );

  always #4 clk = ~clk;

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int idx;
    a = '0;
    idx = -1;
    if (r.mode == MODE_INSERT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (idx < 0 && !cell_valid[i]) idx = i;
      end
      if (idx < 0) begin
        idx = 0;
        for (int i = 1; i < DEPTH; i++) begin
          if (cell_stamp[i] < cell_stamp[idx]) idx = i;
        end
      end
      if (!cell_valid[idx]) begin
        cell_valid[idx] = 1'b1;
        occupancy++;
      end
      cell_key[idx] = r.key;
      cell_stamp[idx] = r.now;
      a.found = 1'b1;
      a.slot = SLOT_W'(idx);
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (idx < 0 && cell_valid[i] && cell_key[i] == r.key) idx = i;
      end
      if (idx >= 0) begin
        a.found = 1'b1;
        a.slot = SLOT_W'(idx);
        if (r.mode == MODE_REFRESH) cell_stamp[idx] = r.now;
      end
    end
    a.used = USED_W'(occupancy);
    return a;
  endfunction

  task automatic queue_request(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                               input logic [KEY_W-1:0] n);
    request_t r;
    r = '{m, k, n};
    requests.push_back(r);
    if (m == MODE_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
    end
  endtask

  always @(posedge clk) begin : drive
    request_t nxt;
    bit present;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) answers_due.push_back(apply_request('{mode, key, now}));
      present = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (requests.size() > 0) begin
        nxt = requests.pop_front();
        present = 1'b1;
        mode <= nxt.mode;
        key <= nxt.key;
        now <= nxt.now;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      start <= present;
    end
  end

  always @(posedge clk) begin : check
    answer_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result at %0t: found=%0d slot=%0d used=%0d",
                   $time, found, slot, used);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (found !== want.found || slot !== want.slot || used !== want.used) begin
          if (mismatches < 10)
            $display({"mismatch at %0t: expected found=%0d slot=%0d used=%0d, ",
                      "got found=%0d slot=%0d used=%0d"},
                     $time, want.found, want.slot, want.used, found, slot, used);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] clock_now;
    logic [KEY_W-1:0] stamp;
    logic [KEY_W-1:0] pick;
    int roll;

    queue_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_SPARE, 32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_REFRESH, 32'h0000_0000, 32'h0000_0007);
    queue_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0005);
    queue_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_REFRESH, 32'h0000_0000, 32'h0000_0064);
    queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(MODE_SPARE, 32'hFFFF_FFFF, 32'h1234_5678);
    queue_request(MODE_REFRESH, 32'h1234_5678, 32'h0000_0009);
    queue_request(MODE_LOOKUP, 32'h5555_5555, 32'h0000_0000);
    queue_request(MODE_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_request(MODE_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_request(MODE_REFRESH, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_request(MODE_LOOKUP, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    queue_request(MODE_REFRESH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(MODE_LOOKUP, 32'h5555_5555, 32'h0000_0000);

    clock_now = 32'd16;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      clock_now += $urandom_range(0, 3);
      roll = $urandom_range(0, 19);
      stamp = (roll == 0) ? $urandom :
              (roll == 1) ? 32'h0000_0000 :
              (roll == 2) ? 32'hFFFF_FFFF : clock_now;
      pick = (key_pool.size() > 0) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                   : $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 40)
        queue_request(MODE_INSERT, ($urandom_range(0, 4) == 0) ? pick : $urandom, stamp);
      else if (roll < 65)
        queue_request(MODE_LOOKUP, ($urandom_range(0, 4) == 0) ? $urandom : pick, stamp);
      else if (roll < 90)
        queue_request(MODE_REFRESH, ($urandom_range(0, 4) == 0) ? $urandom : pick, stamp);
      else if (roll < 95)
        queue_request(MODE_SPARE, pick, stamp);
      else
        queue_request(MODE_LOOKUP, $urandom, $urandom);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (requests.size() != 0 || start || answers_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
